// File: sv/mfd_pkg.sv
// Shared types and constants for the multi-server FCFS dispatcher.
`default_nettype none
package mfd_pkg;

    localparam int TIME_W     = 17;
    localparam int MIN_W      = 10;
    localparam int AWIN_W     = 4;
    localparam int WIN_W      = 3;
    localparam int FREE_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 40;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int SVC_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_OPEN_TIME    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_ARRIVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SERVICE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_WIN   = 2'd3;

    localparam logic [TIME_W-1:0] OPEN_TIME_RST    = 17'd28800;
    localparam logic [TIME_W-1:0] LAST_ARRIVAL_RST = 17'd61200;
    localparam logic [MIN_W-1:0]  MAX_SERVICE_RST  = 10'd60;
    localparam logic [AWIN_W-1:0] ACTIVE_WIN_RST   = 4'd8;

    localparam logic [5:0] SECS_PER_MIN = 6'd60;

    typedef struct packed {
        logic load_job;
        logic scan_step;
        logic select;
        logic update;
        logic out_load;
    } mfd_cmd_t;

    typedef struct packed {
        logic reject;
        logic hit;
        logic last;
    } mfd_status_t;

endpackage
`default_nettype wire

// File: sv/mfd_job_if.sv
// Job input channel: valid/ready handshake with arrival time and service length.
`default_nettype none
interface mfd_job_if;
    logic                        valid;
    logic                        ready;
    logic [mfd_pkg::TIME_W-1:0]  arrival_time;
    logic [mfd_pkg::MIN_W-1:0]   service_minutes;

    modport source (output valid, output arrival_time, output service_minutes, input ready);
    modport sink   (input valid, input arrival_time, input service_minutes, output ready);
endinterface
`default_nettype wire

// File: sv/mfd_result_if.sv
// Result channel: valid/ready handshake with the dispatch decision and totals.
`default_nettype none
interface mfd_result_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [mfd_pkg::WIN_W-1:0]    window;
    logic [mfd_pkg::FREE_W-1:0]   start_time;
    logic [mfd_pkg::FREE_W-1:0]   wait_time;
    logic [mfd_pkg::COUNT_W-1:0]  served_count;
    logic [mfd_pkg::SUM_W-1:0]    total_wait;

    modport source (output valid, output accepted, output window, output start_time,
                    output wait_time, output served_count, output total_wait, input ready);
    modport sink   (input valid, input accepted, input window, input start_time,
                    input wait_time, input served_count, input total_wait, output ready);
endinterface
`default_nettype wire

// File: sv/mfd_ctrl.sv
// Dispatcher controller: sequences load, window scan, select, update and output.
`default_nettype none
module mfd_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire mfd_pkg::mfd_status_t status,
    output mfd_pkg::mfd_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SELECT,
        S_UPDATE,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_job = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.reject)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.hit || status.last)
                        state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: sv/mfd_datapath.sv
// Dispatcher datapath: config registers, window free times, scan, totals, output register.
`default_nettype none
module mfd_datapath
#(
    parameter int WINDOWS = 8
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [mfd_pkg::TIME_W-1:0]         arrival_time,
    input  wire logic [mfd_pkg::MIN_W-1:0]          service_minutes,
    input  wire mfd_pkg::mfd_cmd_t                  cmd,
    output mfd_pkg::mfd_status_t                    status,
    output logic                                    accepted,
    output logic [mfd_pkg::WIN_W-1:0]               window,
    output logic [mfd_pkg::FREE_W-1:0]              start_time,
    output logic [mfd_pkg::FREE_W-1:0]              wait_time,
    output logic [mfd_pkg::COUNT_W-1:0]             served_count,
    output logic [mfd_pkg::SUM_W-1:0]               total_wait
);

    localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam logic [mfd_pkg::FREE_W:0]  FREE_MAX  = {1'b0, {mfd_pkg::FREE_W{1'b1}}};
    localparam logic [mfd_pkg::SUM_W:0]   SUM_MAX   = {1'b0, {mfd_pkg::SUM_W{1'b1}}};
    localparam logic [mfd_pkg::COUNT_W-1:0] COUNT_MAX = {mfd_pkg::COUNT_W{1'b1}};

    // configuration
    logic [mfd_pkg::TIME_W-1:0] open_time_reg;
    logic [mfd_pkg::TIME_W-1:0] last_arrival_reg;
    logic [mfd_pkg::MIN_W-1:0]  max_service_reg;
    logic [mfd_pkg::AWIN_W-1:0] active_win_reg;

    // architectural state
    logic [mfd_pkg::FREE_W-1:0]  free_reg [WINDOWS];
    logic [mfd_pkg::COUNT_W-1:0] count_reg;
    logic [mfd_pkg::SUM_W-1:0]   sum_reg;

    // job working registers
    logic                        reject_reg;
    logic [mfd_pkg::TIME_W-1:0]  arrival_reg;
    logic [mfd_pkg::TIME_W-1:0]  cand_reg;
    logic [mfd_pkg::MIN_W-1:0]   minutes_reg;
    logic [IDX_W-1:0]            last_idx_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            pick_reg;
    logic [mfd_pkg::FREE_W-1:0]  min_reg;
    logic [IDX_W-1:0]            min_idx_reg;
    logic [mfd_pkg::FREE_W-1:0]  start_reg;
    logic [mfd_pkg::FREE_W-1:0]  wait_reg;

    // output register
    logic                          accepted_reg;
    logic [mfd_pkg::WIN_W-1:0]     window_reg;
    logic [mfd_pkg::FREE_W-1:0]    start_out_reg;
    logic [mfd_pkg::FREE_W-1:0]    wait_out_reg;
    logic [mfd_pkg::COUNT_W-1:0]   served_out_reg;
    logic [mfd_pkg::SUM_W-1:0]     total_out_reg;

    logic [mfd_pkg::FREE_W-1:0]  rd_free;
    logic [mfd_pkg::FREE_W-1:0]  cand_ext;
    logic                        rd_hit;
    logic                        rd_less;
    logic [IDX_W-1:0]            last_idx;
    logic [mfd_pkg::MIN_W-1:0]   minutes_capped;
    logic [mfd_pkg::TIME_W-1:0]  cand_start;
    logic [mfd_pkg::FREE_W-1:0]  sel_start;
    logic [mfd_pkg::SVC_W-1:0]   svc_secs;
    logic [mfd_pkg::FREE_W:0]    fin_sum;
    logic [mfd_pkg::FREE_W-1:0]  fin;
    logic [mfd_pkg::SUM_W:0]     wsum;

    always_comb
    begin
        if (active_win_reg == '0)
            last_idx = '0;
        else if (int'(active_win_reg) > WINDOWS)
            last_idx = IDX_W'(WINDOWS - 1);
        else
            last_idx = IDX_W'(int'(active_win_reg) - 1);
    end

    assign minutes_capped = (service_minutes > max_service_reg) ? max_service_reg
                                                                : service_minutes;
    assign cand_start     = (arrival_time > open_time_reg) ? arrival_time : open_time_reg;

    assign rd_free  = free_reg[idx_reg];
    assign cand_ext = {{(mfd_pkg::FREE_W - mfd_pkg::TIME_W){1'b0}}, cand_reg};
    assign rd_hit   = (rd_free <= cand_ext);
    assign rd_less  = (idx_reg == '0) || (rd_free < min_reg);

    assign status.reject = reject_reg;
    assign status.hit    = rd_hit;
    assign status.last   = (idx_reg == last_idx_reg);

    assign sel_start = found_reg ? cand_ext : min_reg;
    assign svc_secs  = mfd_pkg::SVC_W'(minutes_reg) * mfd_pkg::SVC_W'(mfd_pkg::SECS_PER_MIN);
    assign fin_sum   = {1'b0, start_reg} + {{(mfd_pkg::FREE_W + 1 - mfd_pkg::SVC_W){1'b0}}, svc_secs};
    assign fin       = (fin_sum > FREE_MAX) ? FREE_MAX[mfd_pkg::FREE_W-1:0]
                                            : fin_sum[mfd_pkg::FREE_W-1:0];
    assign wsum      = {1'b0, sum_reg} + {{(mfd_pkg::SUM_W + 1 - mfd_pkg::FREE_W){1'b0}}, wait_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_time_reg    <= mfd_pkg::OPEN_TIME_RST;
            last_arrival_reg <= mfd_pkg::LAST_ARRIVAL_RST;
            max_service_reg  <= mfd_pkg::MAX_SERVICE_RST;
            active_win_reg   <= mfd_pkg::ACTIVE_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mfd_pkg::REG_OPEN_TIME:    open_time_reg    <= cfg_wdata;
                mfd_pkg::REG_LAST_ARRIVAL: last_arrival_reg <= cfg_wdata;
                mfd_pkg::REG_MAX_SERVICE:  max_service_reg  <= cfg_wdata[mfd_pkg::MIN_W-1:0];
                mfd_pkg::REG_ACTIVE_WIN:   active_win_reg   <= cfg_wdata[mfd_pkg::AWIN_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOWS; i++)
                free_reg[i] <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.update)
        begin
            free_reg[pick_reg] <= fin;
            if (count_reg != COUNT_MAX)
                count_reg <= count_reg + 1'b1;
            sum_reg <= (wsum > SUM_MAX) ? SUM_MAX[mfd_pkg::SUM_W-1:0] : wsum[mfd_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_job)
        begin
            reject_reg   <= (arrival_time > last_arrival_reg);
            arrival_reg  <= arrival_time;
            cand_reg     <= cand_start;
            minutes_reg  <= minutes_capped;
            last_idx_reg <= last_idx;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= IDX_W'(idx_reg + 1'b1);
            if (rd_hit)
            begin
                found_reg <= 1'b1;
                pick_reg  <= idx_reg;
            end
            else if (rd_less)
            begin
                min_reg     <= rd_free;
                min_idx_reg <= idx_reg;
            end
        end
        if (cmd.select)
        begin
            start_reg <= sel_start;
            wait_reg  <= sel_start - {{(mfd_pkg::FREE_W - mfd_pkg::TIME_W){1'b0}}, arrival_reg};
            if (!found_reg)
                pick_reg <= min_idx_reg;
        end
        if (cmd.out_load)
        begin
            accepted_reg   <= !reject_reg;
            window_reg     <= reject_reg ? '0 : mfd_pkg::WIN_W'(pick_reg);
            start_out_reg  <= reject_reg ? '0 : start_reg;
            wait_out_reg   <= reject_reg ? '0 : wait_reg;
            served_out_reg <= count_reg;
            total_out_reg  <= sum_reg;
        end
    end

    assign accepted     = accepted_reg;
    assign window       = window_reg;
    assign start_time   = start_out_reg;
    assign wait_time    = wait_out_reg;
    assign served_count = served_out_reg;
    assign total_wait   = total_out_reg;

endmodule
`default_nettype wire

// File: sv/multi_server_fcfs_dispatcher.sv
// Multi-server FCFS dispatcher top level: controller, datapath and channel wiring.
// Steps: accept the job, scan the windows from window 0 up to the last active window
//   (stopping at the first free window; a rejected job skips the scan), select, update
//   and load the result register, one job at a time; the scan reads one free time per cycle.
// The result register lets the next item start while a result waits to be taken.
// Reset (rst_n, async, active low): all windows free, totals zero, config at defaults.
`default_nettype none
module multi_server_fcfs_dispatcher
#(
    parameter int WINDOWS = 8
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mfd_job_if.sink                              job,
    mfd_result_if.source                         result,
    input  wire logic                            cfg_we,
    input  wire logic [mfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    mfd_pkg::mfd_cmd_t    cmd;
    mfd_pkg::mfd_status_t status;

    mfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job.valid),
        .in_ready  (job.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mfd_datapath #(
        .WINDOWS (WINDOWS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .arrival_time    (job.arrival_time),
        .service_minutes (job.service_minutes),
        .cmd             (cmd),
        .status          (status),
        .accepted        (result.accepted),
        .window          (result.window),
        .start_time      (result.start_time),
        .wait_time       (result.wait_time),
        .served_count    (result.served_count),
        .total_wait      (result.total_wait)
    );

endmodule
`default_nettype wire

// File: sv/mfd_checker.sv
// Port-level assertions for the dispatcher and their bind to the top level.
`default_nettype none
module mfd_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic                             accepted,
    input wire logic [mfd_pkg::WIN_W-1:0]        window,
    input wire logic [mfd_pkg::FREE_W-1:0]       start_time,
    input wire logic [mfd_pkg::FREE_W-1:0]       wait_time,
    input wire logic [mfd_pkg::COUNT_W-1:0]      served_count,
    input wire logic [mfd_pkg::SUM_W-1:0]        total_wait
);

    // one item in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(start_time) && $stable(total_wait)))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (window == '0 && start_time == '0 && wait_time == '0))
        else $error("rejected item carries schedule fields");

    a_served_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (served_count != '0 && start_time >= wait_time))
        else $error("accepted item with bad totals");

endmodule

bind multi_server_fcfs_dispatcher mfd_checker u_mfd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (job.valid),
    .in_ready     (job.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .accepted     (result.accepted),
    .window       (result.window),
    .start_time   (result.start_time),
    .wait_time    (result.wait_time),
    .served_count (result.served_count),
    .total_wait   (result.total_wait)
);
`default_nettype wire
